FILE: src/stereo_channel_mixer_assert.svh
// Assertion macros shared by the mixer modules.
// Every module that includes this file must have clk and rst_n in scope.
`ifndef STEREO_CHANNEL_MIXER_ASSERT_SVH
`define STEREO_CHANNEL_MIXER_ASSERT_SVH

// Same-cycle implication.
`define SMIX_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smix assertion failed");

// Next-cycle implication.
`define SMIX_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smix assertion failed");

`endif

FILE: src/smix_pkg.sv
package smix_pkg;

  localparam int unsigned MulAW  = 17;
  localparam int unsigned MulBW  = 18;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned GainW  = 17;

  localparam logic signed [31:0] ACC_MAX   = 32'sd8388352;   // 32767 << 8
  localparam logic signed [31:0] ACC_MIN   = -32'sd8388608;  // -32768 << 8
  localparam logic signed [16:0] SAMP_MAX  = 17'sd32767;
  localparam logic signed [16:0] SAMP_MIN  = -17'sd32768;
  localparam logic signed [15:0] OUT_MAX   = 16'sh7fff;
  localparam logic signed [15:0] OUT_MIN   = 16'sh8000;
  localparam logic [7:0]         VOL8_MAX  = 8'd255;
  localparam logic [8:0]         MVOL_RST  = 9'd256;

  typedef struct packed {
    logic load;     // capture the input item
    logic gain;     // form the channel gain for the selected side
    logic mac;      // multiply sample by gain and accumulate
    logic side_r;   // 0 = left, 1 = right
    logic clamp;    // clamp both accumulators
    logic finish;   // add music, scale, saturate, clear accumulators
  } smix_cmd_t;

endpackage

FILE: src/smix_ctrl.sv
module smix_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_req_type,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output smix_pkg::smix_cmd_t cmd
);
  import smix_pkg::*;
  `include "stereo_channel_mixer_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN_L,
    ST_MAC_L,
    ST_GAIN_R,
    ST_MAC_R,
    ST_CLAMP,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;
  logic   fin_go;

  assign in_ready  = (state_r == ST_IDLE) || (state_r == ST_MAC_R);
  assign out_valid = out_valid_r;
  assign take      = in_valid && in_ready;
  // The finished frame may only be written once the output register is free.
  assign fin_go    = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    cmd        = '0;
    cmd.load   = take;
    cmd.gain   = (state_r == ST_GAIN_L) || (state_r == ST_GAIN_R);
    cmd.mac    = (state_r == ST_MAC_L) || (state_r == ST_MAC_R);
    cmd.side_r = (state_r == ST_GAIN_R) || (state_r == ST_MAC_R);
    cmd.clamp  = (state_r == ST_CLAMP);
    cmd.finish = fin_go;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE, ST_MAC_R: begin
        if (take) begin
          state_nxt = in_req_type ? ST_CLAMP : ST_GAIN_L;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_GAIN_L: state_nxt = ST_MAC_L;
      ST_MAC_L:  state_nxt = ST_GAIN_R;
      ST_GAIN_R: state_nxt = ST_MAC_R;
      ST_CLAMP:  state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (fin_go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SMIX_AST_NXT(a_chan_start, take && !in_req_type, state_r == ST_GAIN_L)
  `SMIX_AST_IMP(a_fin_blocked, (state_r == ST_FINISH) && out_valid_r && !out_ready, !cmd.finish)
  `SMIX_AST_NXT(a_fin_valid, cmd.finish, out_valid_r)

endmodule

FILE: src/smix_dp.sv
module smix_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  smix_pkg::smix_cmd_t cmd,
  input  logic                cfg_wr_en,
  input  logic [8:0]          cfg_wr_data,
  input  logic                in_req_type,
  input  logic signed [15:0]  in_sample,
  input  logic                in_is_8bit,
  input  logic [8:0]          in_left_vol,
  input  logic [8:0]          in_right_vol,
  input  logic signed [23:0]  in_music_left,
  input  logic signed [23:0]  in_music_right,
  output logic signed [15:0]  out_left,
  output logic signed [15:0]  out_right
);
  import smix_pkg::*;
  `include "stereo_channel_mixer_assert.svh"

  logic [8:0]          mvol_r;
  logic signed [15:0]  sample_r;
  logic                is_8bit_r;
  logic [8:0]          left_vol_r, right_vol_r;
  logic signed [23:0]  music_l_r, music_r_r;
  logic [GainW-1:0]    gain_r;
  logic signed [31:0]  left_sum_r, right_sum_r;
  logic signed [15:0]  out_left_r, out_right_r;

  logic [8:0]              vol_sel;
  logic [7:0]              vol8;
  logic [8:0]              vol_eff;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic [GainW-1:0]        gain_nxt;
  logic signed [15:0]      smp_eff;
  logic signed [15:0]      fin_l, fin_r;

  function automatic logic signed [31:0] clamp_acc(input logic signed [31:0] v);
    logic signed [31:0] r;
    r = v;
    if (v > ACC_MAX) begin
      r = ACC_MAX;
    end else if (v < ACC_MIN) begin
      r = ACC_MIN;
    end
    return r;
  endfunction

  // The clamped sum fits in 24 bits, so the music add fits in 25.
  function automatic logic signed [15:0] scale_out(input logic signed [31:0] acc,
                                                   input logic signed [23:0] mus);
    logic signed [24:0] v;
    logic signed [16:0] q;
    logic signed [15:0] r;
    v = 25'(acc[24:0]) + {mus[23], mus};
    q = v[24:8];
    r = q[15:0];
    if (q > SAMP_MAX) begin
      r = OUT_MAX;
    end else if (q < SAMP_MIN) begin
      r = OUT_MIN;
    end
    return r;
  endfunction

  assign vol_sel = cmd.side_r ? right_vol_r : left_vol_r;
  assign vol8    = (vol_sel > {1'b0, VOL8_MAX}) ? VOL8_MAX : vol_sel[7:0];
  // The 8-bit path drops the low three volume bits before scaling by eight.
  assign vol_eff = is_8bit_r ? {1'b0, vol8[7:3], 3'b000} : vol_sel;
  assign smp_eff = is_8bit_r ? {{8{sample_r[7]}}, sample_r[7:0]} : sample_r;

  // One shared multiplier: volume by master volume, then sample by gain.
  always_comb begin
    if (cmd.mac) begin
      mul_a = MulAW'(smp_eff);
      mul_b = {1'b0, gain_r};
    end else begin
      mul_a = {{(MulAW-9){1'b0}}, vol_eff};
      mul_b = {{(MulBW-9){1'b0}}, mvol_r};
    end
  end

  assign prod     = mul_a * mul_b;
  assign gain_nxt = is_8bit_r ? prod[GainW-1:0] : {{(GainW-10){1'b0}}, prod[17:8]};

  assign fin_l = scale_out(left_sum_r, music_l_r);
  assign fin_r = scale_out(right_sum_r, music_r_r);

  assign out_left  = out_left_r;
  assign out_right = out_right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvol_r      <= MVOL_RST;
      left_sum_r  <= '0;
      right_sum_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        mvol_r <= cfg_wr_data;
      end
      priority if (cmd.finish) begin
        left_sum_r  <= '0;
        right_sum_r <= '0;
      end else if (cmd.clamp) begin
        left_sum_r  <= clamp_acc(left_sum_r);
        right_sum_r <= clamp_acc(right_sum_r);
      end else if (cmd.mac) begin
        if (cmd.side_r) begin
          right_sum_r <= right_sum_r + prod[31:0];
        end else begin
          left_sum_r  <= left_sum_r + prod[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r    <= in_sample;
      is_8bit_r   <= in_is_8bit && !in_req_type;
      left_vol_r  <= in_left_vol;
      right_vol_r <= in_right_vol;
      music_l_r   <= in_music_left;
      music_r_r   <= in_music_right;
    end
    if (cmd.gain) begin
      gain_r <= gain_nxt;
    end
    if (cmd.finish) begin
      out_left_r  <= fin_l;
      out_right_r <= fin_r;
    end
  end

  `SMIX_AST_NXT(a_sums_clear, cmd.finish, (left_sum_r == 32'sd0) && (right_sum_r == 32'sd0))
  `SMIX_AST_NXT(a_clamp_rng, cmd.clamp, (left_sum_r <= ACC_MAX) && (left_sum_r >= ACC_MIN))
  `SMIX_AST_IMP(a_gain8_low, cmd.mac && is_8bit_r, gain_r[2:0] == 3'b000)

endmodule

FILE: src/stereo_channel_mixer.sv
// Channel  | Ports                                  | Handshake
// ---------+----------------------------------------+----------------
// input    | in_req_type .. in_music_right          | in_valid/in_ready
// result   | out_left, out_right                    | out_valid/out_ready
// config   | cfg_wr_data (master volume)            | cfg_wr_en
//
// A channel item steps through gain and multiply-accumulate for the left
// side, then the right side, all on one shared 17x18 multiplier.
// A frame-end item steps through accept, clamp and finish and yields one result.
// Reset clears the accumulators and sets the master volume to unity (256).
// A frame end waits in its finish step while the previous result is untaken.
module stereo_channel_mixer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [8:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic signed [15:0] in_sample,
  input  logic               in_is_8bit,
  input  logic [8:0]         in_left_vol,
  input  logic [8:0]         in_right_vol,
  input  logic signed [23:0] in_music_left,
  input  logic signed [23:0] in_music_right,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_right
);
  import smix_pkg::*;

  smix_cmd_t cmd;

  smix_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .cmd         (cmd)
  );

  smix_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_req_type    (in_req_type),
    .in_sample      (in_sample),
    .in_is_8bit     (in_is_8bit),
    .in_left_vol    (in_left_vol),
    .in_right_vol   (in_right_vol),
    .in_music_left  (in_music_left),
    .in_music_right (in_music_right),
    .out_left       (out_left),
    .out_right      (out_right)
  );

endmodule
